// ===== rtl/asd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package asd_pkg;

   // register file layout
   localparam int unsigned CsrDataWidth  = 16;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] RegHardThreshold   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] RegGentleThreshold = 2'd1;
   localparam logic [CsrIndexWidth-1:0] RegHardSustain     = 2'd2;
   localparam logic [CsrIndexWidth-1:0] RegGentleSustain   = 2'd3;

   localparam logic [CsrDataWidth-1:0] HardThresholdReset   = 16'd10240;
   localparam logic [CsrDataWidth-1:0] GentleThresholdReset = 16'd6144;
   localparam logic [CsrDataWidth-1:0] HardSustainReset     = 16'd300;
   localparam logic [CsrDataWidth-1:0] GentleSustainReset   = 16'd500;

   // request kinds
   localparam logic ReqSample = 1'b0;
   localparam logic ReqRead   = 1'b1;

   // shake levels
   localparam logic [1:0] LevelNone   = 2'd0;
   localparam logic [1:0] LevelGentle = 2'd1;
   localparam logic [1:0] LevelHard   = 2'd2;

   // magnitude constants, unsigned Q.12 g
   localparam int unsigned   MagWidth = 16;
   localparam logic [15:0]   MagOneG  = 16'd4096;
   localparam logic [15:0]   MagMax   = 16'hFFFF;
   localparam int unsigned   TimeWidth = 32;

   // squaring pass: three components plus one drain step
   localparam int unsigned   SquareSteps = 4;
   localparam logic [1:0]    SelX     = 2'd0;
   localparam logic [1:0]    SelY     = 2'd1;
   localparam logic [1:0]    SelZ     = 2'd2;
   localparam logic [1:0]    SelDrain = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       sq_step;
      logic [1:0] sq_sel;
      logic       root_step;
      logic       commit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_read;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/asd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// request channel: samples and read-and-clear requests
interface asd_req_if #(
   parameter int unsigned ACCEL_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic signed [ACCEL_WIDTH-1:0] accel_x;
   logic signed [ACCEL_WIDTH-1:0] accel_y;
   logic signed [ACCEL_WIDTH-1:0] accel_z;
   logic [31:0]                   now_ms;

   modport source (output valid, req_type, accel_x, accel_y, accel_z, now_ms, input ready);
   modport sink   (input valid, req_type, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

// response channel: pending level and last magnitude
interface asd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  shake_level;
   logic [15:0] accel_mag;

   modport source (output valid, shake_level, accel_mag, input ready);
   modport sink   (input valid, shake_level, accel_mag, output ready);
endinterface

`default_nettype wire

// ===== rtl/asd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asd_datapath #(
   parameter int unsigned ACCEL_WIDTH = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire asd_pkg::cmd_type        cmd,
   output asd_pkg::status_type          status,
   input  wire                          req_type,
   input  wire [ACCEL_WIDTH-1:0]        accel_x,
   input  wire [ACCEL_WIDTH-1:0]        accel_y,
   input  wire [ACCEL_WIDTH-1:0]        accel_z,
   input  wire [31:0]                   now_ms,
   input  wire                          csr_wr_en,
   input  wire [asd_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire [asd_pkg::CsrDataWidth-1:0]  csr_wr_data,
   output logic [1:0]                   shake_level,
   output logic [15:0]                  accel_mag
);

   localparam int unsigned AW = ACCEL_WIDTH;
   localparam int unsigned PW = 2 * AW;
   localparam int unsigned SW = 2 * AW + 2;
   localparam int unsigned RW = SW / 2;

   // configuration registers
   logic [15:0] hard_thr_ff, gentle_thr_ff, hard_sus_ff, gentle_sus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hard_thr_ff   <= asd_pkg::HardThresholdReset;
         gentle_thr_ff <= asd_pkg::GentleThresholdReset;
         hard_sus_ff   <= asd_pkg::HardSustainReset;
         gentle_sus_ff <= asd_pkg::GentleSustainReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            asd_pkg::RegHardThreshold:   hard_thr_ff   <= csr_wr_data;
            asd_pkg::RegGentleThreshold: gentle_thr_ff <= csr_wr_data;
            asd_pkg::RegHardSustain:     hard_sus_ff   <= csr_wr_data;
            asd_pkg::RegGentleSustain:   gentle_sus_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // captured transaction: type, absolute components, timestamp
   logic          type_ff;
   logic [AW-1:0] abs_x_ff, abs_y_ff, abs_z_ff;
   logic [31:0]   now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= req_type;
         abs_x_ff <= accel_x[AW-1] ? (AW'(0) - accel_x) : accel_x;
         abs_y_ff <= accel_y[AW-1] ? (AW'(0) - accel_y) : accel_y;
         abs_z_ff <= accel_z[AW-1] ? (AW'(0) - accel_z) : accel_z;
         now_ff   <= now_ms;
      end
   end

   assign status.is_read = type_ff;

   // shared squarer, product registered before accumulation
   logic [AW-1:0] sq_op;
   logic [PW-1:0] prod_ff, prod_in;
   logic [SW-1:0] acc_ff, acc_in;

   always_comb begin
      case (cmd.sq_sel)
         asd_pkg::SelX: sq_op = abs_x_ff;
         asd_pkg::SelY: sq_op = abs_y_ff;
         asd_pkg::SelZ: sq_op = abs_z_ff;
         default:       sq_op = '0;
      endcase
   end

   // digit-by-digit square root, one root bit per step
   logic [RW:0]   rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [RW+1:0] rem_sh, trial, rem_diff;

   assign rem_sh   = {rem_ff[RW-1:0], acc_ff[SW-1:SW-2]};
   assign trial    = {root_ff, 2'b01};
   assign rem_diff = rem_sh - trial;

   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.sq_step) begin
         prod_in = PW'(sq_op * sq_op);
         acc_in  = (cmd.sq_sel == asd_pkg::SelX) ? '0 : (acc_ff + SW'(prod_ff));
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.root_step) begin
         acc_in = {acc_ff[SW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_diff[RW:0];
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RW:0];
            root_in = {root_ff[RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   // saturate root to the magnitude width
   logic [31:0] root_wide;
   logic [15:0] mag;

   assign root_wide = 32'(root_ff);
   assign mag = (root_wide > 32'(asd_pkg::MagMax)) ? asd_pkg::MagMax : root_wide[15:0];

   // episode tracking
   logic        episode_ff, episode_in;
   logic [31:0] start_ff, start_in;
   logic [1:0]  pending_ff, pending_in;
   logic [15:0] last_mag_ff, last_mag_in;
   logic        is_hard, is_gentle;
   logic [31:0] age, need;

   assign is_hard   = mag >= hard_thr_ff;
   assign is_gentle = mag >= gentle_thr_ff;
   assign age       = now_ff - start_ff;
   assign need      = is_hard ? 32'(hard_sus_ff) : 32'(gentle_sus_ff);

   always_comb begin
      episode_in  = episode_ff;
      start_in    = start_ff;
      pending_in  = pending_ff;
      last_mag_in = last_mag_ff;
      if (cmd.commit) begin
         if (type_ff == asd_pkg::ReqRead) begin
            pending_in = asd_pkg::LevelNone;
         end else begin
            last_mag_in = mag;
            if (is_hard || is_gentle) begin
               if (!episode_ff) begin
                  episode_in = 1'b1;
                  start_in   = now_ff;
               end else if (age >= need && pending_ff == asd_pkg::LevelNone) begin
                  pending_in = is_hard ? asd_pkg::LevelHard : asd_pkg::LevelGentle;
               end
            end else begin
               episode_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         episode_ff  <= 1'b0;
         start_ff    <= '0;
         pending_ff  <= asd_pkg::LevelNone;
         last_mag_ff <= asd_pkg::MagOneG;
      end else begin
         episode_ff  <= episode_in;
         start_ff    <= start_in;
         pending_ff  <= pending_in;
         last_mag_ff <= last_mag_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         shake_level <= (type_ff == asd_pkg::ReqRead) ? pending_ff : pending_in;
         accel_mag   <= last_mag_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/asd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asd_ctrl #(
   parameter int unsigned ROOT_STEPS = 17
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   input  wire asd_pkg::status_type status,
   output asd_pkg::cmd_type      cmd
);

   localparam int unsigned CW = $clog2(ROOT_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_UPDATE
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] cnt_ff;
   logic          rsp_valid_ff;
   logic          accept;
   logic          out_free;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // commands decoded from state
   always_comb begin
      cmd.load      = accept;
      cmd.sq_step   = (state_ff == ST_SQUARE) && !status.is_read;
      cmd.sq_sel    = cnt_ff[1:0];
      cmd.root_step = (state_ff == ST_ROOT);
      cmd.commit    = (state_ff == ST_UPDATE) && out_free;
   end

   // sequencer and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept) begin
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               // a read skips the arithmetic once its captured type is seen
               if (status.is_read) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_UPDATE;
               end else if (cnt_ff == CW'(asd_pkg::SquareSteps - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_ROOT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_ROOT: begin
               if (cnt_ff == CW'(ROOT_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_UPDATE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_UPDATE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/accel_shake_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shake detector for a three-axis accelerometer. A sample transaction (req_type 0) carries
// signed Q3.12 g components and a millisecond timestamp; the block forms the floored root of
// the sum of squares, updates the shake episode and returns the pending level and magnitude.
// A read transaction (req_type 1) returns the pending level and clears it. One transaction is
// worked on at a time: a sample passes through the shared squarer, then the square root, which
// yields one result bit per cycle, ACCEL_WIDTH + 1 bits in all, and then the update state; a
// read goes from the state that sees its captured type straight to the update. The request
// side is ready again the cycle after the update, so a new request is taken only after the
// last one's update. The next request is taken while a finished response still waits on
// rsp.ready; that transaction then holds in its update state until the response is taken.
// Thresholds and sustain times are written through the csr port; the user must write them only
// while the block is idle, and the block itself does not enforce this.
module accel_shake_detector #(
   parameter int unsigned ACCEL_WIDTH = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   asd_req_if.sink                          req,
   asd_rsp_if.source                        rsp,
   input  wire                              csr_wr_en,
   input  wire [asd_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire [asd_pkg::CsrDataWidth-1:0]  csr_wr_data
);

   localparam int unsigned RootSteps = ACCEL_WIDTH + 1;

   asd_pkg::cmd_type    cmd;
   asd_pkg::status_type status;

   // sequencer
   asd_ctrl #(
      .ROOT_STEPS(RootSteps)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and episode state
   asd_datapath #(
      .ACCEL_WIDTH(ACCEL_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req.req_type),
      .accel_x     (req.accel_x),
      .accel_y     (req.accel_y),
      .accel_z     (req.accel_z),
      .now_ms      (req.now_ms),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .shake_level (rsp.shake_level),
      .accel_mag   (rsp.accel_mag)
   );

endmodule

`default_nettype wire

// ===== sim/accel_shake_detector_tb.sv =====
`timescale 1ns / 1ps

module accel_shake_detector_tb;
   import asd_pkg::*;

   localparam int unsigned AccelWidth  = 16;
   localparam int unsigned MagCeiling  = 56755;
   localparam int unsigned StallLimit  = 5000;
   localparam int unsigned SettleCycles = 40;
   localparam int unsigned HoldCycles  = 300;

   typedef struct packed {
      logic                         req_type;
      logic signed [AccelWidth-1:0] accel_x;
      logic signed [AccelWidth-1:0] accel_y;
      logic signed [AccelWidth-1:0] accel_z;
      logic [TimeWidth-1:0]         now_ms;
   } shake_request_type;

   typedef struct packed {
      logic [1:0]          level;
      logic [MagWidth-1:0] mag;
   } shake_result_type;

   typedef enum logic [1:0] {BandQuiet, BandGentle, BandHard} band_type;

   logic clock;
   logic reset;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wr_data;

   asd_req_if #(.ACCEL_WIDTH(AccelWidth)) req_ch ();
   asd_rsp_if rsp_ch ();

   accel_shake_detector #(.ACCEL_WIDTH(AccelWidth)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the detector: thresholds, sustain times and episode state
   logic [15:0]          thr_hard;
   logic [15:0]          thr_gentle;
   logic [15:0]          sus_hard;
   logic [15:0]          sus_gentle;
   logic                 episode_open;
   logic [TimeWidth-1:0] episode_t0;
   logic [1:0]           pending_shake;
   logic [MagWidth-1:0]  last_mag;

   shake_result_type expected_shakes [$];

   logic [TimeWidth-1:0] stamp_ms;
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned hold_request;
   int unsigned idle_cycles;
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned samples_sent;
   int unsigned reads_sent;
   int unsigned results_checked;
   int unsigned gentle_seen;
   int unsigned hard_seen;
   int unsigned config_phases;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // floored square root, one result bit at a time from the top
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned cand;
      root = 0;
      for (int b = 20; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= n) root = cand;
      end
      return root;
   endfunction

   function automatic longint unsigned comp_mag(logic signed [AccelWidth-1:0] v);
      logic signed [AccelWidth:0] w;
      w = v;
      if (w < 0) w = -w;
      return w;
   endfunction

   // expected response for one accepted transaction, updates the shadow state
   function automatic shake_result_type predict_shake(shake_request_type it);
      shake_result_type res;
      longint unsigned  sum;
      longint unsigned  root;
      logic [TimeWidth-1:0] age;
      logic [15:0]      need;
      logic             is_hard;
      if (it.req_type == ReqRead) begin
         res.level     = pending_shake;
         res.mag       = last_mag;
         pending_shake = LevelNone;
         return res;
      end
      sum = comp_mag(it.accel_x) * comp_mag(it.accel_x)
          + comp_mag(it.accel_y) * comp_mag(it.accel_y)
          + comp_mag(it.accel_z) * comp_mag(it.accel_z);
      root = floor_sqrt(sum);
      last_mag = (root > MagMax) ? MagMax : root[MagWidth-1:0];
      if (last_mag >= thr_hard || last_mag >= thr_gentle) begin
         is_hard = (last_mag >= thr_hard);
         if (!episode_open) begin
            // opening sample only records the start time
            episode_open = 1'b1;
            episode_t0   = it.now_ms;
         end else begin
            age  = it.now_ms - episode_t0;
            need = is_hard ? sus_hard : sus_gentle;
            if (age >= need && pending_shake == LevelNone)
               pending_shake = is_hard ? LevelHard : LevelGentle;
         end
      end else begin
         episode_open = 1'b0;
      end
      res.level = pending_shake;
      res.mag   = last_mag;
      return res;
   endfunction

   function automatic void apply_register(logic [CsrIndexWidth-1:0] idx, logic [15:0] val);
      case (idx)
         RegHardThreshold:   thr_hard   = val;
         RegGentleThreshold: thr_gentle = val;
         RegHardSustain:     sus_hard   = val;
         RegGentleSustain:   sus_gentle = val;
         default: ;
      endcase
   endfunction

   // magnitude aimed at a band of the current thresholds
   function automatic int unsigned band_target(band_type kind);
      int unsigned lo_thr;
      int unsigned base;
      int unsigned top;
      lo_thr = (thr_hard < thr_gentle) ? thr_hard : thr_gentle;
      if (kind == BandGentle && thr_hard <= thr_gentle) kind = BandHard;
      case (kind)
         BandQuiet: begin
            if (lo_thr == 0) return 0;
            if (lo_thr - 1 > MagCeiling) return $urandom_range(MagCeiling);
            return $urandom_range(3) == 0 ? lo_thr - 1 : $urandom_range(lo_thr - 1);
         end
         BandGentle: begin
            if (thr_gentle > MagCeiling) return MagCeiling;
            top = (thr_hard - 1 > MagCeiling) ? MagCeiling : thr_hard - 1;
            return $urandom_range(3) == 0 ? thr_gentle : $urandom_range(top, thr_gentle);
         end
         default: begin
            base = (thr_hard > MagCeiling) ? MagCeiling : thr_hard;
            top  = (base + 4000 > MagCeiling) ? MagCeiling : base + 4000;
            return $urandom_range(3) == 0 ? base : $urandom_range(top, base);
         end
      endcase
   endfunction

   function automatic logic signed [AccelWidth-1:0] random_sign(int unsigned c);
      logic signed [AccelWidth-1:0] v;
      v = c[AccelWidth-1:0];
      return $urandom_range(1) ? -v : v;
   endfunction

   // sample whose magnitude lands near m, spread over all three axes
   function automatic shake_request_type aimed_sample(int unsigned m, logic [TimeWidth-1:0] t);
      shake_request_type it;
      longint unsigned   rest;
      longint unsigned   lm;
      int unsigned       comp [3];
      int unsigned       rot;
      lm      = m;
      comp[1] = $urandom_range(m / 2);
      comp[2] = $urandom_range(m / 2);
      rest    = lm * lm - longint'(comp[1]) * comp[1] - longint'(comp[2]) * comp[2];
      comp[0] = 32'(floor_sqrt(rest));
      if (comp[0] > 32767) comp[0] = 32767;
      rot = $urandom_range(2);
      it.req_type = ReqSample;
      it.accel_x  = random_sign(comp[rot]);
      it.accel_y  = random_sign(comp[(rot + 1) % 3]);
      it.accel_z  = random_sign(comp[(rot + 2) % 3]);
      it.now_ms   = t;
      return it;
   endfunction

   function automatic shake_request_type read_item();
      shake_request_type it;
      it.req_type = ReqRead;
      it.accel_x  = AccelWidth'($urandom);
      it.accel_y  = AccelWidth'($urandom);
      it.accel_z  = AccelWidth'($urandom);
      it.now_ms   = $urandom;
      return it;
   endfunction

   // anything at all: random kind, full-range components, jumpy timestamps
   function automatic shake_request_type noise_item();
      shake_request_type it;
      it.req_type = $urandom_range(1) ? ReqRead : ReqSample;
      it.accel_x  = AccelWidth'($urandom);
      it.accel_y  = AccelWidth'($urandom);
      it.accel_z  = AccelWidth'($urandom);
      stamp_ms    = $urandom_range(1) ? stamp_ms + $urandom_range(1000) : $urandom;
      it.now_ms   = stamp_ms;
      return it;
   endfunction

   function automatic int unsigned episode_step(band_type kind);
      int unsigned need;
      need = (kind == BandHard) ? sus_hard : sus_gentle;
      return $urandom_range(need / 2 + 2);
   endfunction

   // offer one transaction, hold it until taken, then record what it should return
   task automatic send_item(input shake_request_type it);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= it.req_type;
      req_ch.accel_x  <= it.accel_x;
      req_ch.accel_y  <= it.accel_y;
      req_ch.accel_z  <= it.accel_z;
      req_ch.now_ms   <= it.now_ms;
      do @(posedge clock); while (!req_ch.ready);
      expected_shakes.push_back(predict_shake(it));
      items_sent++;
      if (it.req_type == ReqRead) reads_sent++;
      else samples_sent++;
   endtask

   task automatic send_sample(input logic signed [AccelWidth-1:0] x, y, z,
                              input logic [TimeWidth-1:0] t);
      shake_request_type it;
      it.req_type = ReqSample;
      it.accel_x  = x;
      it.accel_y  = y;
      it.accel_z  = z;
      it.now_ms   = t;
      send_item(it);
   endtask

   // stop offering and let every outstanding response come back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_shakes.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic program_thresholds(input logic [15:0] hard_thr, gentle_thr,
                                     input logic [15:0] hard_ms, gentle_ms);
      logic [15:0]              vals [4];
      logic [CsrIndexWidth-1:0] regs [4];
      vals = '{hard_thr, gentle_thr, hard_ms, gentle_ms};
      regs = '{RegHardThreshold, RegGentleThreshold, RegHardSustain, RegGentleSustain};
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= regs[i];
         csr_wr_data <= vals[i];
         @(posedge clock);
         apply_register(regs[i], vals[i]);
      end
      csr_wr_en <= 1'b0;
      config_phases++;
   endtask

   // mostly full episodes with random content, some noise in between
   task automatic run_random(input int unsigned count);
      int unsigned stop_at;
      int unsigned len;
      band_type    kind;
      band_type    k;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 70) begin
            kind = $urandom_range(1) ? BandHard : BandGentle;
            len  = $urandom_range(8, 2);
            for (int i = 0; i < len; i++) begin
               k = kind;
               if ($urandom_range(9) == 0) k = (kind == BandHard) ? BandGentle : BandHard;
               stamp_ms += episode_step(k);
               send_item(aimed_sample(band_target(k), stamp_ms));
               if ($urandom_range(9) == 0) send_item(read_item());
            end
            if ($urandom_range(4) != 0) begin
               stamp_ms += $urandom_range(200);
               send_item(aimed_sample(band_target(BandQuiet), stamp_ms));
            end
            if ($urandom_range(3) != 0) send_item(read_item());
         end else begin
            send_item(noise_item());
         end
      end
   endtask

   // response side: random stalls, long hold-off on request, check each transaction
   initial begin
      int unsigned hold_left;
      shake_result_type want;
      hold_left    = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_shakes.size() == 0) begin
               $error("unexpected response: shake_level %0d accel_mag %0d",
                      rsp_ch.shake_level, rsp_ch.accel_mag);
               error_count++;
            end else begin
               want = expected_shakes.pop_front();
               results_checked++;
               if (want.level == LevelGentle) gentle_seen++;
               if (want.level == LevelHard) hard_seen++;
               if (rsp_ch.shake_level !== want.level) begin
                  $error("shake_level: expected %0d, actual %0d", want.level, rsp_ch.shake_level);
                  error_count++;
               end
               if (rsp_ch.accel_mag !== want.mag) begin
                  $error("accel_mag: expected %0d, actual %0d", want.mag, rsp_ch.accel_mag);
                  error_count++;
               end
            end
         end
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("accel_shake_detector_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // edge values of the fields, special cases of the episode rules, at the reset thresholds
   task automatic test_directed();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_item(read_item());
      send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'd10);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd100);
      // hard sustain reached exactly
      send_sample(16'sd32767, -16'sd32768, 16'sd0, 32'd310);
      // pending level is never overwritten
      send_sample(16'sd0, 16'sd20000, 16'sd0, 32'd400);
      send_item(read_item());
      send_item(read_item());
      send_sample(16'sd4096, 16'sd0, 16'sd0, 32'd500);
      // gentle episode opened at exactly the gentle threshold
      send_sample(16'sd6144, 16'sd0, 16'sd0, 32'd600);
      send_sample(16'sd8000, -16'sd1000, 16'sd0, 32'd1099);
      send_sample(16'sd0, 16'sd0, 16'sd6144, 32'd1100);
      send_item(read_item());
      send_sample(16'sd6143, 16'sd0, 16'sd0, 32'd1200);
      // episode age across the timestamp wrap
      send_sample(16'sd10240, 16'sd0, 16'sd0, 32'hFFFF_FF00);
      send_sample(-16'sd10240, 16'sd0, 16'sd0, 32'h0000_0030);
      send_item(read_item());
      send_sample(16'sd1, -16'sd1, 16'sd0, 32'h0000_0040);
      // gentle opening followed by a hard level
      send_sample(16'sd7000, 16'sd0, 16'sd0, 32'd1000);
      send_sample(16'sd0, 16'sd0, -16'sd20000, 32'd1300);
      send_item(read_item());
      send_sample(16'sd32767, -16'sd32768, 16'sd21845, 32'hFFFF_FFFF);
      send_item(read_item());
      send_sample(-16'sd1, -16'sd1, -16'sd1, 32'd5);
      send_item(read_item());
      stamp_ms = 32'd5;
   endtask

   task automatic test_no_idle();
      program_thresholds(16'd12000, 16'd5000, 16'd40, 16'd120);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_random(250);
   endtask

   // equal thresholds count as hard; zero sustain still needs a second sample
   task automatic test_sender_idle();
      program_thresholds(16'd8000, 16'd8000, 16'd0, 16'd0);
      sender_idle_pct    = 46;
      receiver_stall_pct = 0;
      run_random(200);
   endtask

   // hard threshold below the gentle one
   task automatic test_receiver_stall();
      program_thresholds(16'd5000, 16'd9000, 16'd250, 16'd60);
      sender_idle_pct    = 0;
      receiver_stall_pct = 46;
      run_random(200);
   endtask

   task automatic test_both_idle();
      int unsigned hard_thr;
      hard_thr = $urandom_range(20000, 4000);
      program_thresholds(16'(hard_thr), 16'($urandom_range(hard_thr, 2000)),
                         16'($urandom_range(1500)), 16'($urandom_range(1500)));
      sender_idle_pct    = 14;
      receiver_stall_pct = 14;
      run_random(200);
   endtask

   task automatic test_extreme_config();
      sender_idle_pct    = 14;
      receiver_stall_pct = 14;
      program_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
      run_random(60);
      program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(60);
      program_thresholds(16'd20000, 16'd7000, 16'hFFFF, 16'hFFFF);
      run_random(60);
   endtask

   // response side holds off while requests keep coming, so the block backs up
   task automatic test_backpressure();
      program_thresholds(HardThresholdReset, GentleThresholdReset,
                         HardSustainReset, GentleSustainReset);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request       = HoldCycles;
      run_random(40);
      sender_idle_pct    = 14;
      receiver_stall_pct = 14;
      run_random(60);
   endtask

   initial begin
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_index   <= RegHardThreshold;
      csr_wr_data <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= ReqSample;
      req_ch.accel_x  <= '0;
      req_ch.accel_y  <= '0;
      req_ch.accel_z  <= '0;
      req_ch.now_ms   <= '0;
      thr_hard      = HardThresholdReset;
      thr_gentle    = GentleThresholdReset;
      sus_hard      = HardSustainReset;
      sus_gentle    = GentleSustainReset;
      episode_open  = 1'b0;
      episode_t0    = '0;
      pending_shake = LevelNone;
      last_mag      = MagOneG;
      stamp_ms      = '0;
      hold_request  = 0;
      idle_cycles   = 0;
      error_count   = 0;
      items_sent    = 0;
      samples_sent  = 0;
      reads_sent    = 0;
      results_checked = 0;
      gentle_seen   = 0;
      hard_seen     = 0;
      config_phases = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_extreme_config();
      test_backpressure();
      wait_idle();

      $display("covered %0d samples and %0d reads across %0d threshold settings,",
               samples_sent, reads_sent, config_phases);
      $display("four idle patterns and a long response hold-off; %0d checked, %0d gentle, %0d hard",
               results_checked, gentle_seen, hard_seen);
      if (error_count == 0 && expected_shakes.size() == 0)
         $display("accel_shake_detector_tb passed");
      else
         $display("accel_shake_detector_tb failed");
      $finish;
   end

endmodule
